// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bhpq_pkg.sv =====
// Package for the binary heap priority queue: sizes, types, codes, helpers.
// No dependencies; used by bhpq_cell and the top level.
`timescale 1ns / 1ps

package bhpq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int KEY_WIDTH  = 32;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int NUM_LEVELS = COUNT_W;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int OFF_W      = NUM_LEVELS - 1;

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [COUNT_W-1:0]          count_t;
    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [LVL_W-1:0]            lvl_t;
    typedef logic [OFF_W-1:0]            off_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_DN_RD,
        ST_DN_CMP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t cmd;
        key_t key_in;
    } in_item_t;

    typedef struct packed {
        key_t    key_out;
        status_t status;
        count_t  entry_count;
    } out_item_t;

    // Heap slot as (level, offset within level).
    typedef struct packed {
        lvl_t lvl;
        off_t off;
    } pos_t;

    // Memory request broadcast from the sequencer to all level cells.
    typedef struct packed {
        logic rd_en;
        lvl_t rd_lvl_a;
        off_t rd_off_a;
        lvl_t rd_lvl_b;
        off_t rd_off_b;
        logic wr_en;
        lvl_t wr_lvl;
        off_t wr_off;
        key_t wr_data;
    } mem_req_t;

    // Per-level RAM controls produced by a cell.
    typedef struct packed {
        logic we;
        off_t wr_off;
        key_t wr_data;
        off_t rd_off_a;
        off_t rd_off_b;
    } ram_ctl_t;

    // a belongs nearer the root than b.
    function automatic logic outranks(input key_t a, input key_t b, input logic order_min);
        return order_min ? (a < b) : (a > b);
    endfunction

    // Number of slots held by one level.
    function automatic int level_depth(input int lvl);
        int first;
        int cnt;
        first = (1 << lvl) - 1;
        cnt   = CAPACITY - first;
        return (cnt < (1 << lvl)) ? cnt : (1 << lvl);
    endfunction

    // Slot of array index v-1: level is the top set bit of v, offset the rest.
    function automatic pos_t pos_of(input count_t v);
        pos_t p;
        p.lvl = '0;
        p.off = v[OFF_W-1:0];
        for (int i = 0; i < COUNT_W; i++) begin
            if (v[i]) p.lvl = LVL_W'(i);
        end
        for (int i = 0; i < OFF_W; i++) begin
            if (LVL_W'(i) == p.lvl) p.off[i] = 1'b0;
        end
        return p;
    endfunction

endpackage

// ===== rtl/bhpq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies; one instance per heap level.
`timescale 1ns / 1ps

module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem_reg[rd_addr_a];
        rd_data_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== rtl/bhpq_cell.sv =====
// One heap level cell: decodes the shared request for its level's RAM and
// joins its read data into the return chain. Depends on bhpq_pkg.
`timescale 1ns / 1ps

module bhpq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  bhpq_pkg::lvl_t     cell_level,
    input  bhpq_pkg::mem_req_t req,
    output bhpq_pkg::ram_ctl_t ram_ctl,
    input  bhpq_pkg::key_t     ram_rd_a,
    input  bhpq_pkg::key_t     ram_rd_b,
    input  bhpq_pkg::key_t     chain_in_a,
    input  bhpq_pkg::key_t     chain_in_b,
    output bhpq_pkg::key_t     chain_out_a,
    output bhpq_pkg::key_t     chain_out_b
);

    logic hit_a_reg, hit_a_next;
    logic hit_b_reg, hit_b_next;

    always_comb begin
        ram_ctl.we       = req.wr_en && (req.wr_lvl == cell_level);
        ram_ctl.wr_off   = req.wr_off;
        ram_ctl.wr_data  = req.wr_data;
        ram_ctl.rd_off_a = req.rd_off_a;
        ram_ctl.rd_off_b = req.rd_off_b;
        hit_a_next       = req.rd_en && (req.rd_lvl_a == cell_level);
        hit_b_next       = req.rd_en && (req.rd_lvl_b == cell_level);
    end

    // Hit flags line up with the RAM's registered read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else begin
            hit_a_reg <= hit_a_next;
            hit_b_reg <= hit_b_next;
        end
    end

    assign chain_out_a = hit_a_reg ? ram_rd_a : chain_in_a;
    assign chain_out_b = hit_b_reg ? ram_rd_b : chain_in_b;

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: sequencer, level cells, RAMs.
// Depends on bhpq_pkg, bhpq_cell, bhpq_ram and assert_macros.svh.
//
// Priority queue of signed 32-bit keys kept as an array binary heap of up to
// 1024 entries. Each request on s_ is a push (key appended, sifted up) or a pop
// (root returned, last entry moved to the root and sifted down, left child
// winning a tie); each request yields exactly one result on m_ with the popped
// key (zero unless a pop succeeds), a status (ok, pop on empty, push on full;
// a failed request changes nothing) and the entry count afterwards. cfg_data
// written through cfg_valid/cfg_ready selects the order: 0 keeps the largest
// key at the root, 1 the smallest; write it only while no request is in
// flight. Changing it does not reorder stored keys. One request is in flight
// at a time; a new one is taken while the previous result still waits on m_.
// The heap lives in one RAM per tree level, driven by a row of level cells;
// a sift walks one level per step: a registered RAM read, then a compare
// and write. A finished result waits until the previous one has been taken
// on m_ready. No clearing pass runs after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_heap_priority_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bhpq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bhpq_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam int CHILD_W = bhpq_pkg::IDX_W + 2;

    // Sequencer state and datapath registers
    bhpq_pkg::state_t  state_reg, state_next;
    bhpq_pkg::count_t  fill_reg, fill_next;
    bhpq_pkg::key_t    key_reg, key_next;          // key being sifted
    bhpq_pkg::key_t    pop_key_reg, pop_key_next;  // reported key_out
    bhpq_pkg::status_t status_reg, status_next;
    bhpq_pkg::lvl_t    lvl_reg, lvl_next;          // current slot
    bhpq_pkg::off_t    off_reg, off_next;
    bhpq_pkg::idx_t    idx_reg, idx_next;
    logic              order_min_reg;

    bhpq_pkg::out_item_t out_reg;
    logic                m_valid_reg;

    bhpq_pkg::mem_req_t mem_req;
    bhpq_pkg::key_t     rd_a, rd_b;

    logic s_fire;
    logic result_load;

    bhpq_pkg::pos_t last_pos;   // slot of the last entry (pop)
    bhpq_pkg::pos_t tail_pos;   // first free slot (push)

    logic [CHILD_W-1:0] left_w, right_w, fill_w, child_idx_w;
    logic               left_ok, right_ok;
    logic               pick_left, pick_right, moving_down;
    bhpq_pkg::key_t     best_val;
    logic               up_win;

    assign s_ready     = (state_reg == bhpq_pkg::ST_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign cfg_ready   = 1'b1;
    assign result_load = (state_reg == bhpq_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    assign last_pos = bhpq_pkg::pos_of(fill_reg);
    assign tail_pos = bhpq_pkg::pos_of(bhpq_pkg::COUNT_W'(fill_reg + 1'b1));

    // Child tests of the current slot against the fill count
    assign left_w      = {1'b0, idx_reg, 1'b1};
    assign right_w     = CHILD_W'(left_w + 1'b1);
    assign fill_w      = CHILD_W'(fill_reg);
    assign left_ok     = left_w < fill_w;
    assign right_ok    = right_w < fill_w;

    assign pick_left   = bhpq_pkg::outranks(rd_a, key_reg, order_min_reg);
    assign best_val    = pick_left ? rd_a : key_reg;
    assign pick_right  = right_ok && bhpq_pkg::outranks(rd_b, best_val, order_min_reg);
    assign moving_down = pick_left || pick_right;
    assign child_idx_w = CHILD_W'(left_w + CHILD_W'(pick_right));

    assign up_win      = bhpq_pkg::outranks(key_reg, rd_a, order_min_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bhpq_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.cmd == bhpq_pkg::CMD_POP) begin
                        state_next = (fill_reg == '0) ? bhpq_pkg::ST_DONE
                                                      : bhpq_pkg::ST_POP_WAIT;
                    end else begin
                        state_next = (fill_reg == bhpq_pkg::COUNT_W'(bhpq_pkg::CAPACITY))
                                     ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_UP_RD;
                    end
                end
            end
            bhpq_pkg::ST_POP_WAIT: begin
                state_next = (fill_reg == '0) ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_DN_RD;
            end
            bhpq_pkg::ST_DN_RD: begin
                state_next = left_ok ? bhpq_pkg::ST_DN_CMP : bhpq_pkg::ST_DONE;
            end
            bhpq_pkg::ST_DN_CMP: begin
                state_next = moving_down ? bhpq_pkg::ST_DN_RD : bhpq_pkg::ST_DONE;
            end
            bhpq_pkg::ST_UP_RD: begin
                state_next = (idx_reg == '0) ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_UP_CMP;
            end
            bhpq_pkg::ST_UP_CMP: begin
                state_next = up_win ? bhpq_pkg::ST_UP_RD : bhpq_pkg::ST_DONE;
            end
            bhpq_pkg::ST_DONE: begin
                if (result_load) state_next = bhpq_pkg::ST_IDLE;
            end
            default: state_next = bhpq_pkg::ST_IDLE;
        endcase
    end

    // Memory requests. The sifted key is written only at its final slot;
    // every slot it passes gets the promoted neighbor instead.
    always_comb begin
        mem_req = '0;
        unique case (state_reg)
            bhpq_pkg::ST_IDLE: begin
                // pop: fetch root and last entry together
                if (s_fire && (s_data.cmd == bhpq_pkg::CMD_POP) && (fill_reg != '0)) begin
                    mem_req.rd_en    = 1'b1;
                    mem_req.rd_lvl_a = '0;
                    mem_req.rd_off_a = '0;
                    mem_req.rd_lvl_b = last_pos.lvl;
                    mem_req.rd_off_b = last_pos.off;
                end
            end
            bhpq_pkg::ST_DN_RD: begin
                if (left_ok) begin
                    mem_req.rd_en    = 1'b1;
                    mem_req.rd_lvl_a = bhpq_pkg::LVL_W'(lvl_reg + 1'b1);
                    mem_req.rd_off_a = bhpq_pkg::OFF_W'({off_reg, 1'b0});
                    mem_req.rd_lvl_b = bhpq_pkg::LVL_W'(lvl_reg + 1'b1);
                    mem_req.rd_off_b = bhpq_pkg::OFF_W'({off_reg, 1'b1});
                end else begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_lvl  = lvl_reg;
                    mem_req.wr_off  = off_reg;
                    mem_req.wr_data = key_reg;
                end
            end
            bhpq_pkg::ST_DN_CMP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_lvl  = lvl_reg;
                mem_req.wr_off  = off_reg;
                mem_req.wr_data = pick_right ? rd_b : best_val;
            end
            bhpq_pkg::ST_UP_RD: begin
                if (idx_reg == '0) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_lvl  = lvl_reg;
                    mem_req.wr_off  = off_reg;
                    mem_req.wr_data = key_reg;
                end else begin
                    mem_req.rd_en    = 1'b1;
                    mem_req.rd_lvl_a = bhpq_pkg::LVL_W'(lvl_reg - 1'b1);
                    mem_req.rd_off_a = off_reg >> 1;
                end
            end
            bhpq_pkg::ST_UP_CMP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_lvl  = lvl_reg;
                mem_req.wr_off  = off_reg;
                mem_req.wr_data = up_win ? rd_a : key_reg;
            end
            bhpq_pkg::ST_POP_WAIT,
            bhpq_pkg::ST_DONE: begin
                mem_req = '0;
            end
            default: mem_req = '0;
        endcase
    end

    // Datapath next values
    always_comb begin
        fill_next    = fill_reg;
        key_next     = key_reg;
        pop_key_next = pop_key_reg;
        status_next  = status_reg;
        lvl_next     = lvl_reg;
        off_next     = off_reg;
        idx_next     = idx_reg;
        case (state_reg)
            bhpq_pkg::ST_IDLE: begin
                if (s_fire) begin
                    status_next  = bhpq_pkg::STATUS_OK;
                    pop_key_next = '0;
                    if (s_data.cmd == bhpq_pkg::CMD_POP) begin
                        if (fill_reg == '0) begin
                            status_next = bhpq_pkg::STATUS_EMPTY;
                        end else begin
                            fill_next = bhpq_pkg::COUNT_W'(fill_reg - 1'b1);
                        end
                    end else begin
                        if (fill_reg == bhpq_pkg::COUNT_W'(bhpq_pkg::CAPACITY)) begin
                            status_next = bhpq_pkg::STATUS_FULL;
                        end else begin
                            fill_next = bhpq_pkg::COUNT_W'(fill_reg + 1'b1);
                            key_next  = s_data.key_in;
                            lvl_next  = tail_pos.lvl;
                            off_next  = tail_pos.off;
                            idx_next  = bhpq_pkg::IDX_W'(fill_reg);
                        end
                    end
                end
            end
            bhpq_pkg::ST_POP_WAIT: begin
                pop_key_next = rd_a;
                key_next     = rd_b;
                lvl_next     = '0;
                off_next     = '0;
                idx_next     = '0;
            end
            bhpq_pkg::ST_DN_CMP: begin
                if (moving_down) begin
                    lvl_next = bhpq_pkg::LVL_W'(lvl_reg + 1'b1);
                    off_next = bhpq_pkg::OFF_W'({off_reg, pick_right});
                    idx_next = bhpq_pkg::IDX_W'(child_idx_w);
                end
            end
            bhpq_pkg::ST_UP_CMP: begin
                if (up_win) begin
                    lvl_next = bhpq_pkg::LVL_W'(lvl_reg - 1'b1);
                    off_next = off_reg >> 1;
                    idx_next = bhpq_pkg::IDX_W'((idx_reg - 1'b1) >> 1);
                end
            end
            default: begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bhpq_pkg::ST_IDLE;
            fill_reg      <= '0;
            order_min_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_valid && cfg_ready) begin
                order_min_reg <= cfg_data;
            end
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        pop_key_reg <= pop_key_next;
        status_reg  <= status_next;
        lvl_reg     <= lvl_next;
        off_reg     <= off_next;
        idx_reg     <= idx_next;
        if (result_load) begin
            out_reg.key_out     <= pop_key_reg;
            out_reg.status      <= status_reg;
            out_reg.entry_count <= fill_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Level cells and their RAMs; read data returns along the cell chain
    bhpq_pkg::ram_ctl_t ram_ctl   [bhpq_pkg::NUM_LEVELS];
    bhpq_pkg::key_t     ram_rd_a  [bhpq_pkg::NUM_LEVELS];
    bhpq_pkg::key_t     ram_rd_b  [bhpq_pkg::NUM_LEVELS];
    bhpq_pkg::key_t     chain_a   [bhpq_pkg::NUM_LEVELS + 1];
    bhpq_pkg::key_t     chain_b   [bhpq_pkg::NUM_LEVELS + 1];

    assign chain_a[bhpq_pkg::NUM_LEVELS] = '0;
    assign chain_b[bhpq_pkg::NUM_LEVELS] = '0;
    assign rd_a = chain_a[0];
    assign rd_b = chain_b[0];

    for (genvar g = 0; g < bhpq_pkg::NUM_LEVELS; g++) begin : g_level
        localparam int LVL_DEPTH = bhpq_pkg::level_depth(g);
        localparam int LVL_AW    = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

        bhpq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_level  (bhpq_pkg::LVL_W'(g)),
            .req         (mem_req),
            .ram_ctl     (ram_ctl[g]),
            .ram_rd_a    (ram_rd_a[g]),
            .ram_rd_b    (ram_rd_b[g]),
            .chain_in_a  (chain_a[g + 1]),
            .chain_in_b  (chain_b[g + 1]),
            .chain_out_a (chain_a[g]),
            .chain_out_b (chain_b[g])
        );

        bhpq_ram #(
            .WIDTH (bhpq_pkg::KEY_WIDTH),
            .DEPTH (LVL_DEPTH)
        ) u_ram (
            .aclk      (aclk),
            .wr_en     (ram_ctl[g].we),
            .wr_addr   (ram_ctl[g].wr_off[LVL_AW-1:0]),
            .wr_data   (ram_ctl[g].wr_data),
            .rd_addr_a (ram_ctl[g].rd_off_a[LVL_AW-1:0]),
            .rd_data_a (ram_rd_a[g]),
            .rd_addr_b (ram_ctl[g].rd_off_b[LVL_AW-1:0]),
            .rd_data_b (ram_rd_b[g])
        );
    end

    // Assertions
    `ASSERT_IMPLIES(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= bhpq_pkg::COUNT_W'(bhpq_pkg::CAPACITY), "fill count above capacity")
    `ASSERT_IMPLIES(a_idle_no_write, aclk, aresetn, state_reg == bhpq_pkg::ST_IDLE, !mem_req.wr_en, "heap write while idle")
    `ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, state_reg != bhpq_pkg::ST_IDLE, "request accepted but sequencer stayed idle")
    `ASSERT_IMPLIES(a_empty_count, aclk, aresetn, m_valid && (m_data.status == bhpq_pkg::STATUS_EMPTY), m_data.entry_count == '0, "empty status with nonzero count")
    `ASSERT_IMPLIES(a_full_count, aclk, aresetn, m_valid && (m_data.status == bhpq_pkg::STATUS_FULL), m_data.entry_count == bhpq_pkg::COUNT_W'(bhpq_pkg::CAPACITY), "full status below capacity")

endmodule
